[sv/ped_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ped_pkg;

	localparam int MAX_LINE_WIDTH = 4096;
	localparam int COL_W          = 12;
	localparam int LW_W           = 13;
	localparam int SAMPLE_W       = 16;
	localparam int DER_W          = 18;
	localparam int DIFF_W         = 19;
	localparam int LINE_W         = 16;
	localparam int THR_W          = 17;
	localparam int COEFF_W        = 16;
	localparam int OFF_W          = 9;
	localparam int IDX_W          = 3;
	localparam int FIFO_DEPTH     = 4;
	localparam int FIFO_PTR_W     = 2;

	localparam logic [IDX_W-1:0] REG_LINE_WIDTH   = 3'd0;
	localparam logic [IDX_W-1:0] REG_POLARITY     = 3'd1;
	localparam logic [IDX_W-1:0] REG_REVERSE_SCAN = 3'd2;
	localparam logic [IDX_W-1:0] REG_THRESHOLD    = 3'd3;
	localparam logic [IDX_W-1:0] REG_FILTER_EN    = 3'd4;
	localparam logic [IDX_W-1:0] REG_CENTER_COEFF = 3'd5;
	localparam logic [IDX_W-1:0] REG_SIDE_COEFF   = 3'd6;

	typedef struct packed {
		logic [LW_W-1:0]    line_width;
		logic               polarity;
		logic               reverse_scan;
		logic [THR_W-1:0]   threshold;
		logic               filter_enable;
		logic [COEFF_W-1:0] center_coeff;
		logic [COEFF_W-1:0] side_coeff;
	} cfg_t;

	// one detected peak waiting for sub-pixel refinement
	typedef struct packed {
		logic [COL_W-1:0]         column;
		logic signed [DER_W-1:0]  peak;
		logic signed [DIFF_W-1:0] diff_a;
		logic signed [DIFF_W-1:0] diff_b;
		logic [LINE_W-1:0]        line;
		logic                     last;
	} cand_t;

endpackage
`default_nettype wire

[sv/ped_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface ped_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] sample;
	logic        line_end;
	modport source(output valid, sample, line_end, input ready);
	modport sink(input valid, sample, line_end, output ready);
endinterface

interface ped_out_if;
	logic               valid;
	logic               ready;
	logic [11:0]        edge_column;
	logic signed [8:0]  subpixel_offset;
	logic signed [17:0] edge_strength;
	logic [15:0]        line_number;
	logic               last_of_burst;
	modport source(output valid, edge_column, subpixel_offset, edge_strength, line_number,
		last_of_burst, input ready);
	modport sink(input valid, edge_column, subpixel_offset, edge_strength, line_number,
		last_of_burst, output ready);
endinterface

interface ped_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/ped_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
module ped_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire ped_pkg::cand_t push_data,
	output logic                full,
	input  wire logic           pop,
	output ped_pkg::cand_t      pop_data,
	output logic                empty
);
	ped_pkg::cand_t                  mem_q [ped_pkg::FIFO_DEPTH];
	logic [ped_pkg::FIFO_PTR_W-1:0]  wr_q;
	logic [ped_pkg::FIFO_PTR_W-1:0]  rd_q;
	logic [ped_pkg::FIFO_PTR_W:0]    cnt_q;

	assign full     = (cnt_q == (ped_pkg::FIFO_PTR_W+1)'(ped_pkg::FIFO_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("pop from empty queue");
endmodule
`default_nettype wire

[sv/ped_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module ped_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	ped_in_if.sink             samples,
	input  wire ped_pkg::cfg_t cfg,
	output logic               push,
	output ped_pkg::cand_t     push_data,
	input  wire logic          full
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL1 = 4'd1;
	localparam logic [3:0] S_MUL2 = 4'd2;
	localparam logic [3:0] S_FA   = 4'd3;
	localparam logic [3:0] S_CA   = 4'd4;
	localparam logic [3:0] S_FB   = 4'd5;
	localparam logic [3:0] S_CB   = 4'd6;
	localparam logic [3:0] S_DC   = 4'd7;
	localparam logic [3:0] S_CC   = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;

	localparam logic [ped_pkg::LW_W-1:0] LW_MAX = ped_pkg::LW_W'(ped_pkg::MAX_LINE_WIDTH);

	logic [3:0]                           state_q;
	logic [ped_pkg::SAMPLE_W-1:0]         sw0_q, sw1_q, sw2_q;
	logic [ped_pkg::SAMPLE_W-1:0]         fw1_q, fw2_q;
	logic signed [ped_pkg::DER_W-1:0]     dw0_q, dw1_q, dw2_q;
	logic [ped_pkg::COL_W-1:0]            col_q;
	logic [ped_pkg::LINE_W-1:0]           line_q;
	logic                                 end_q;
	logic [32:0]                          prod_q;
	logic [33:0]                          acc_q;
	logic                                 chk_q;
	logic [ped_pkg::COL_W-1:0]            chk_col_q;
	logic                                 pend_v_q;
	ped_pkg::cand_t                       pend_q;

	logic [ped_pkg::LW_W-1:0]             eff_w;
	logic [33:0]                          rnd;
	logic [ped_pkg::SAMPLE_W-1:0]         fsat;
	logic [ped_pkg::SAMPLE_W-1:0]         fp_val;
	logic [ped_pkg::COL_W-1:0]            fp_j;
	logic                                 do_fp;
	logic signed [ped_pkg::DER_W-1:0]     d_new;
	logic signed [ped_pkg::DIFF_W-1:0]    y1e, y2e, y3e, thr_e;
	logic                                 hit, in_check, stall;
	ped_pkg::cand_t                       cand;

	always_comb begin
		if (cfg.line_width < ped_pkg::LW_W'(3)) eff_w = ped_pkg::LW_W'(3);
		else if (cfg.line_width > LW_MAX) eff_w = LW_MAX;
		else eff_w = cfg.line_width;
	end

	assign samples.ready = (state_q == S_IDLE);

	// rounded and saturated kernel output
	assign rnd  = acc_q + 34'd32768;
	assign fsat = (|rnd[33:32]) ? '1 : rnd[31:16];

	always_comb begin
		if (state_q == S_FB) begin
			fp_val = sw2_q;
			fp_j   = col_q;
		end else begin
			fp_val = (col_q == 12'd1 || !cfg.filter_enable) ? sw1_q : fsat;
			fp_j   = col_q - 1'b1;
		end
	end
	assign do_fp = (state_q == S_FA && col_q != '0) || (state_q == S_FB);
	assign d_new = ped_pkg::DER_W'($signed({2'b00, fw1_q}) - $signed({2'b00, fp_val}));

	// peak test on the derivative window
	assign y1e   = {dw0_q[17], dw0_q};
	assign y2e   = {dw1_q[17], dw1_q};
	assign y3e   = {dw2_q[17], dw2_q};
	assign thr_e = $signed({2'b00, cfg.threshold});
	always_comb begin
		if (cfg.polarity) hit = chk_q && (y2e > thr_e) && (y2e >= y1e) && (y2e >= y3e);
		else hit = chk_q && (y2e < -thr_e) && (y2e <= y1e) && (y2e <= y3e);
	end
	assign in_check = (state_q == S_CA) || (state_q == S_CB) || (state_q == S_CC);
	assign stall    = in_check && hit && pend_v_q && full;

	always_comb begin
		cand.column = cfg.reverse_scan ?
			ped_pkg::COL_W'(eff_w - 13'd1 - {1'b0, chk_col_q}) : chk_col_q;
		cand.peak   = dw1_q;
		cand.diff_a = y1e - y2e;
		cand.diff_b = y3e - y2e;
		cand.line   = line_q;
		cand.last   = 1'b0;
	end

	// a held peak goes out once the next one shows up or the item is done
	assign push = (in_check && hit && pend_v_q && !full) ||
		(state_q == S_FIN && pend_v_q && !full);
	always_comb begin
		push_data      = pend_q;
		push_data.last = (state_q == S_FIN);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MUL1) begin
			prod_q <= cfg.side_coeff * ({1'b0, sw0_q} + {1'b0, sw2_q});
		end
		if (state_q == S_MUL2) begin
			acc_q <= {1'b0, prod_q} + {2'b00, 32'(cfg.center_coeff) * 32'(sw1_q)};
		end
		if (in_check && hit && !stall) begin
			pend_q <= cand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sw0_q     <= '0;
			sw1_q     <= '0;
			sw2_q     <= '0;
			fw1_q     <= '0;
			fw2_q     <= '0;
			dw0_q     <= '0;
			dw1_q     <= '0;
			dw2_q     <= '0;
			col_q     <= '0;
			line_q    <= '0;
			end_q     <= 1'b0;
			chk_q     <= 1'b0;
			chk_col_q <= '0;
			pend_v_q  <= 1'b0;
		end else begin
			if (do_fp) begin
				fw1_q <= fw2_q;
				fw2_q <= fp_val;
			end
			case (state_q)
				S_IDLE: begin
					if (samples.valid) begin
						sw0_q   <= sw1_q;
						sw1_q   <= sw2_q;
						sw2_q   <= samples.sample;
						end_q   <= samples.line_end || (({1'b0, col_q} + 13'd1) >= eff_w);
						state_q <= S_MUL1;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_FA;
				S_FA, S_FB: begin
					chk_q <= 1'b0;
					if (do_fp) begin
						if (fp_j == '0) begin
							dw0_q <= dw1_q;
							dw1_q <= dw2_q;
							dw2_q <= '0;
						end else if (fp_j >= 12'd2) begin
							dw0_q     <= dw1_q;
							dw1_q     <= dw2_q;
							dw2_q     <= d_new;
							chk_q     <= (fp_j >= 12'd3);
							chk_col_q <= fp_j - 12'd2;
						end
					end
					state_q <= (state_q == S_FA) ? S_CA : S_CB;
				end
				S_DC: begin
					chk_q <= 1'b0;
					if (col_q != '0) begin
						dw0_q     <= dw1_q;
						dw1_q     <= dw2_q;
						dw2_q     <= '0;
						chk_q     <= (col_q >= 12'd2);
						chk_col_q <= col_q - 1'b1;
					end
					state_q <= S_CC;
				end
				S_CA, S_CB, S_CC: begin
					if (!stall) begin
						if (hit) pend_v_q <= 1'b1;
						if (state_q == S_CA) state_q <= end_q ? S_FB : S_FIN;
						else if (state_q == S_CB) state_q <= S_DC;
						else state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!pend_v_q || !full) begin
						pend_v_q <= 1'b0;
						if (end_q) begin
							col_q  <= '0;
							line_q <= line_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("peak left pending across items");
endmodule
`default_nettype wire

[sv/ped_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module ped_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	output logic                pop,
	input  wire ped_pkg::cand_t pop_data,
	input  wire logic           empty,
	ped_out_if.source           edges
);
	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_PREP = 2'd1;
	localparam logic [1:0] B_DIV  = 2'd2;
	localparam logic [1:0] B_OUT  = 2'd3;
	localparam int DVD_W = 40;
	localparam int DVS_W = 22;
	localparam logic [5:0] LAST_STEP = 6'(DVD_W - 1);

	logic [1:0]                 state_q;
	ped_pkg::cand_t             c_q;
	logic                       den_neg_q, num_neg_q, sel_q;
	logic [18:0]                dmag_q;
	logic [DVD_W-1:0]           sq_q;
	logic [DVD_W-1:0]           dvd_q;
	logic [DVS_W-1:0]           dvs_q;
	logic [DVS_W-1:0]           rem_q;
	logic [5:0]                 cnt_q;
	logic signed [8:0]          off_q;
	logic signed [17:0]         str_q;

	logic signed [19:0]         sum, dif, num_n;
	logic [19:0]                dmag, nmag;
	logic [DVS_W:0]             rem_sh;
	logic                       ge;
	logic [DVD_W-1:0]           quo;
	logic [DVD_W-1:0]           qc;
	logic signed [DVD_W+1:0]    str_w;

	assign sum   = {c_q.diff_a[18], c_q.diff_a} + {c_q.diff_b[18], c_q.diff_b};
	assign dif   = {c_q.diff_a[18], c_q.diff_a} - {c_q.diff_b[18], c_q.diff_b};
	assign num_n = sum[19] ? -dif : dif;
	assign dmag  = sum[19] ? 20'(-sum) : 20'(sum);
	assign nmag  = num_n[19] ? 20'(-num_n) : 20'(num_n);

	// restoring divider, one quotient bit per cycle
	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};
	assign quo    = {dvd_q[DVD_W-2:0], ge};
	assign qc     = (quo > 40'd128) ? 40'd128 : quo;
	assign str_w  = den_neg_q ? ($signed({{24{c_q.peak[17]}}, c_q.peak}) + $signed({2'b00, quo}))
		: ($signed({{24{c_q.peak[17]}}, c_q.peak}) - $signed({2'b00, quo}));

	assign pop                   = (state_q == B_IDLE) && !empty;
	assign edges.valid           = (state_q == B_OUT);
	assign edges.edge_column     = c_q.column;
	assign edges.subpixel_offset = off_q;
	assign edges.edge_strength   = str_q;
	assign edges.line_number     = c_q.line;
	assign edges.last_of_burst   = c_q.last;

	always_ff @(posedge clk) begin
		if (pop) c_q <= pop_data;
		if (state_q == B_PREP) begin
			den_neg_q <= sum[19];
			num_neg_q <= num_n[19];
			dmag_q    <= dmag[18:0];
			sq_q      <= DVD_W'(dif) * DVD_W'(dif);
			dvd_q     <= DVD_W'({nmag, 7'b0}) + DVD_W'(dmag[19:1]);
			dvs_q     <= DVS_W'(dmag);
			rem_q     <= '0;
			cnt_q     <= '0;
			sel_q     <= 1'b0;
			off_q     <= '0;
			str_q     <= c_q.peak;
		end
		if (state_q == B_DIV) begin
			rem_q <= ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
			dvd_q <= quo;
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP) begin
				if (!sel_q) begin
					off_q <= num_neg_q ? 9'(-$signed({1'b0, qc[7:0]})) : 9'(qc[8:0]);
					dvd_q <= sq_q + DVD_W'({dmag_q, 2'b00});
					dvs_q <= DVS_W'({dmag_q, 3'b000});
					rem_q <= '0;
					cnt_q <= '0;
					sel_q <= 1'b1;
				end else begin
					if (str_w > 42'sd131071) str_q <= 18'sd131071;
					else if (str_w < -42'sd131072) str_q <= -18'sd131072;
					else str_q <= str_w[17:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			case (state_q)
				B_IDLE: if (!empty) state_q <= B_PREP;
				B_PREP: begin
					if (c_q.diff_a == '0 || c_q.diff_b == '0) state_q <= B_OUT;
					else state_q <= B_DIV;
				end
				B_DIV: if (cnt_q == LAST_STEP && sel_q) state_q <= B_OUT;
				B_OUT: if (edges.ready) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		edges.valid |-> (off_q <= 9'sd128 && off_q >= -9'sd128))
		else $error("sub-pixel offset out of range");
endmodule
`default_nettype wire

[sv/profile_edge_detector.sv]
`timescale 1ns / 1ps
`default_nettype none
// Caliper edge detector for averaged scan-line profiles. Samples arrive one per transfer in
// column order; a line ends at a sample with line_end set or at column line_width-1 (clamped
// to 3..4096). The samples are smoothed with a symmetric 3-tap kernel when filter_enable
// is set (ends left as they are), differentiated by central difference, and local extremes
// past the threshold of the chosen polarity are reported with a parabolic sub-pixel offset
// and interpolated strength, each peak test able to yield an edge and the last edge of a
// sample flagged last_of_burst. The front end takes a new sample only once its sequencer
// is done with the last one (it walks filter multiply, window updates and up to three peak
// tests) and waits for room in the result queue; peaks wait in a 4-entry queue, and the
// back end takes one edge at a time, working through two 40-step serial divisions, or
// skipping them when the parabola is flat on one side. The output register holds a result
// until it is taken while the front end keeps filling the queue. Configuration writes are
// taken at any time and should only be issued while the block is idle.
module profile_edge_detector (
	input  wire logic clk,
	input  wire logic arst_n,
	ped_in_if.sink    samples,
	ped_out_if.source edges,
	ped_cfg_if.sink   cfg
);
	ped_pkg::cfg_t  cfg_q;
	logic           q_push, q_full, q_pop, q_empty;
	ped_pkg::cand_t q_wdata, q_rdata;

	// register file, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_width    <= 13'd800;
			cfg_q.polarity      <= 1'b0;
			cfg_q.reverse_scan  <= 1'b0;
			cfg_q.threshold     <= 17'd20480;
			cfg_q.filter_enable <= 1'b1;
			cfg_q.center_coeff  <= 16'd40000;
			cfg_q.side_coeff    <= 16'd12768;
		end else if (cfg.valid) begin
			case (cfg.index)
				ped_pkg::REG_LINE_WIDTH:   cfg_q.line_width    <= cfg.data[12:0];
				ped_pkg::REG_POLARITY:     cfg_q.polarity      <= cfg.data[0];
				ped_pkg::REG_REVERSE_SCAN: cfg_q.reverse_scan  <= cfg.data[0];
				ped_pkg::REG_THRESHOLD:    cfg_q.threshold     <= cfg.data[16:0];
				ped_pkg::REG_FILTER_EN:    cfg_q.filter_enable <= cfg.data[0];
				ped_pkg::REG_CENTER_COEFF: cfg_q.center_coeff  <= cfg.data[15:0];
				ped_pkg::REG_SIDE_COEFF:   cfg_q.side_coeff    <= cfg.data[15:0];
				default: ; // unused index, transfer dropped
			endcase
		end
	end

	// front end: filter, derivative and peak tests
	ped_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.cfg       (cfg_q),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full)
	);

	// peaks waiting for refinement
	ped_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	// back end: parabola vertex and strength
	ped_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop      (q_pop),
		.pop_data (q_rdata),
		.empty    (q_empty),
		.edges    (edges)
	);
endmodule
`default_nettype wire
